// ===== rtl/sipsc_pkg.sv =====
// Shared constants and types for the streaming SipHash core.
// Holds the lane initialisation words, register indexes and the command beat
// passed from the front end to the round engine. No dependencies.
package sipsc_pkg;

  localparam logic [63:0] INIT0 = 64'h736f6d6570736575;
  localparam logic [63:0] INIT1 = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT2 = 64'h6c7967656e657261;
  localparam logic [63:0] INIT3 = 64'h7465646279746573;

  localparam logic [7:0] FINAL_MARK = 8'hff;
  localparam logic [3:0] BLOCK_BYTES = 4'd8;

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_COMP     = 2'd2;
  localparam logic [1:0] REG_FIN      = 2'd3;

  localparam logic [3:0] COMP_ROUNDS_RST = 4'd2;
  localparam logic [3:0] FIN_ROUNDS_RST  = 4'd4;

  typedef struct packed {
    logic        start;
    logic        has_block;
    logic        last;
    logic [63:0] block;
    logic [63:0] tail;
  } cmd_t;

endpackage

// ===== rtl/sipsc_front.sv =====
// Front end of the streaming SipHash core: packs input bytes into blocks.
// Emits one command beat per item that starts a message, fills a block or
// ends a message. Depends on sipsc_pkg.
module sipsc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [63:0]        in_message_bytes,
  input  logic [3:0]         in_byte_count,
  input  logic               in_last_item,
  output logic               cmd_push,
  output sipsc_pkg::cmd_t    cmd
);

  logic        in_msg_r;
  logic [55:0] pend_r;
  logic [2:0]  cnt_r;
  logic [7:0]  len_r;

  logic [3:0]   n;
  logic [63:0]  data;
  logic [2:0]   pc;
  logic [55:0]  pb;
  logic [7:0]   len;
  logic [127:0] shifted;
  logic [63:0]  low;
  logic [55:0]  high;
  logic [3:0]   sum;
  logic [7:0]   len_nxt;
  logic [55:0]  pend_nxt;

  always_comb begin
    n = (in_byte_count > sipsc_pkg::BLOCK_BYTES) ? sipsc_pkg::BLOCK_BYTES : in_byte_count;
    for (int i = 0; i < 8; i++) begin
      data[8*i +: 8] = (4'(i) < n) ? in_message_bytes[8*i +: 8] : 8'h00;
    end
    pc       = in_msg_r ? cnt_r : 3'd0;
    pb       = in_msg_r ? pend_r : 56'd0;
    len      = in_msg_r ? len_r : 8'd0;
    shifted  = {64'd0, data} << {pc, 3'b000};
    low      = {8'h00, pb} | shifted[63:0];
    high     = shifted[119:64];
    sum      = {1'b0, pc} + n;
    len_nxt  = len + {4'h0, n};
    pend_nxt = sum[3] ? high : low[55:0];

    cmd.start     = !in_msg_r;
    cmd.has_block = sum[3];
    cmd.last      = in_last_item;
    cmd.block     = low;
    cmd.tail      = {len_nxt, pend_nxt};
    cmd_push      = accept && (!in_msg_r || sum[3] || in_last_item);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      pend_r   <= 56'd0;
      cnt_r    <= 3'd0;
      len_r    <= 8'd0;
    end else if (accept) begin
      if (in_last_item) begin
        in_msg_r <= 1'b0;
      end else begin
        in_msg_r <= 1'b1;
        pend_r   <= pend_nxt;
        cnt_r    <= sum[2:0];
        len_r    <= len_nxt;
      end
    end
  end

endmodule

// ===== rtl/sipsc_cmd_fifo.sv =====
// Short command queue between the front end and the round engine.
// Register based, one write and one read a cycle. Depends on sipsc_pkg.
module sipsc_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sipsc_pkg::cmd_t wr_data,
  output logic            full,
  input  logic            pop,
  output sipsc_pkg::cmd_t rd_data,
  output logic            valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sipsc_pkg::cmd_t entries_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  logic do_push;
  logic do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign rd_data = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/sipsc_back.sv =====
// Round engine of the streaming SipHash core: one SipRound per cycle.
// Absorbs blocks, finalises, and holds the digest in an output register.
// Depends on sipsc_pkg.
module sipsc_back #(
  parameter int MAX_ROUNDS = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [63:0]     key_low,
  input  logic [63:0]     key_high,
  input  logic [3:0]      comp_rounds,
  input  logic [3:0]      fin_rounds,
  input  logic            cmd_valid,
  input  sipsc_pkg::cmd_t cmd,
  output logic            cmd_pop,
  output logic            busy,
  output logic            out_valid,
  output logic [63:0]     out_digest,
  input  logic            out_pop
);

  localparam int CW = $clog2(MAX_ROUNDS + 1);
  localparam logic [CW-1:0] MAX_R = CW'(MAX_ROUNDS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BLK  = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
    return (x << s) | (x >> (64 - s));
  endfunction

  function automatic lanes_t sip_round(input lanes_t s);
    lanes_t r;
    logic [63:0] a, b, c, d;
    a = s.v0; b = s.v1; c = s.v2; d = s.v3;
    a = a + b; c = c + d;
    b = rotl(b, 13); d = rotl(d, 16);
    b = b ^ a; d = d ^ c;
    a = rotl(a, 32);
    c = c + b; a = a + d;
    b = rotl(b, 17); d = rotl(d, 21);
    b = b ^ c; d = d ^ a;
    c = rotl(c, 32);
    r.v0 = a; r.v1 = b; r.v2 = c; r.v3 = d;
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp(input logic [3:0] rounds);
    if (32'(rounds) > MAX_ROUNDS) begin
      return MAX_R;
    end
    return CW'(rounds);
  endfunction

  logic [1:0]    state_r, state_nxt;
  lanes_t        lanes_r, lanes_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0]   m_r, m_nxt;
  logic [63:0]   tail_r, tail_nxt;
  logic          last_r, last_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   digest_r, digest_nxt;

  lanes_t        base;
  logic [CW-1:0] rounds_c;
  logic [CW-1:0] rounds_f;
  logic [63:0]   fold;

  always_comb begin
    state_nxt     = state_r;
    lanes_nxt     = lanes_r;
    cnt_nxt       = cnt_r;
    m_nxt         = m_r;
    tail_nxt      = tail_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    digest_nxt    = digest_r;
    cmd_pop       = 1'b0;
    base          = lanes_r;
    rounds_c      = clamp(comp_rounds);
    rounds_f      = clamp(fin_rounds);
    fold          = lanes_r.v0 ^ lanes_r.v1 ^ lanes_r.v2 ^ lanes_r.v3;

    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.start) begin
            base.v0 = key_low ^ sipsc_pkg::INIT0;
            base.v1 = key_high ^ sipsc_pkg::INIT1;
            base.v2 = key_low ^ sipsc_pkg::INIT2;
            base.v3 = key_high ^ sipsc_pkg::INIT3;
          end
          lanes_nxt = base;
          tail_nxt  = cmd.tail;
          last_nxt  = cmd.last;
          cnt_nxt   = rounds_c;
          if (cmd.has_block) begin
            lanes_nxt.v3 = base.v3 ^ cmd.block;
            m_nxt        = cmd.block;
            state_nxt    = ST_BLK;
          end else if (cmd.last) begin
            lanes_nxt.v3 = base.v3 ^ cmd.tail;
            m_nxt        = cmd.tail;
            state_nxt    = ST_TAIL;
          end
        end
      end
      ST_BLK: begin
        if (cnt_r != '0) begin
          lanes_nxt = sip_round(lanes_r);
          cnt_nxt   = cnt_r - CW'(1);
        end else begin
          lanes_nxt.v0 = lanes_r.v0 ^ m_r;
          if (last_r) begin
            lanes_nxt.v3 = lanes_r.v3 ^ tail_r;
            m_nxt        = tail_r;
            cnt_nxt      = rounds_c;
            state_nxt    = ST_TAIL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (cnt_r != '0) begin
          lanes_nxt = sip_round(lanes_r);
          cnt_nxt   = cnt_r - CW'(1);
        end else begin
          lanes_nxt.v0 = lanes_r.v0 ^ m_r;
          lanes_nxt.v2 = lanes_r.v2 ^ {56'd0, sipsc_pkg::FINAL_MARK};
          cnt_nxt      = rounds_f;
          state_nxt    = ST_FIN;
        end
      end
      ST_FIN: begin
        if (cnt_r != '0) begin
          lanes_nxt = sip_round(lanes_r);
          cnt_nxt   = cnt_r - CW'(1);
        end else if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          digest_nxt    = fold;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lanes_r  <= lanes_nxt;
    cnt_r    <= cnt_nxt;
    m_r      <= m_nxt;
    tail_r   <= tail_nxt;
    digest_r <= digest_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_digest = digest_r;

endmodule

// ===== rtl/siphash_streaming_cd_core.sv =====
// Top level of the streaming keyed SipHash-c-d core with its register port.
// Instantiates sipsc_front, sipsc_cmd_fifo and sipsc_back; uses sipsc_pkg.
//
//   channel   ports                                              flow control
//   input     in_message_bytes, in_byte_count, in_last_item      push / full
//   result    out_digest                                          empty / pop
//   config    psel, penable, pwrite, paddr, pwdata, prdata       pready (tied high)
//
// The front end takes one beat per cycle while the command queue has room.
// The round engine runs C rounds on each full block in ST_BLK, C = compression rounds.
// A last beat without a full block runs ST_TAIL then ST_FIN, F = finalisation rounds;
// a last beat that also fills a block runs ST_BLK, ST_TAIL and ST_FIN in turn.
// Reset is synchronous and leaves no clearing pass; a waiting digest blocks
// only the finalisation step, and a full command queue raises full.
module siphash_streaming_cd_core #(
  parameter int MAX_ROUNDS = 15,
  parameter int CMD_DEPTH  = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_message_bytes,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_item,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_digest,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] key_low_r;
  logic [63:0] key_high_r;
  logic [3:0]  comp_rounds_r;
  logic [3:0]  fin_rounds_r;

  logic            accept;
  logic            cmd_push;
  sipsc_pkg::cmd_t cmd_in;
  sipsc_pkg::cmd_t cmd_out;
  logic            cmd_full;
  logic            cmd_valid;
  logic            cmd_pop;
  logic            back_busy;
  logic            out_valid;
  logic            cfg_wr;
  logic [1:0]      cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r     <= 64'd0;
      key_high_r    <= 64'd0;
      comp_rounds_r <= sipsc_pkg::COMP_ROUNDS_RST;
      fin_rounds_r  <= sipsc_pkg::FIN_ROUNDS_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        sipsc_pkg::REG_KEY_LOW:  key_low_r     <= pwdata;
        sipsc_pkg::REG_KEY_HIGH: key_high_r    <= pwdata;
        sipsc_pkg::REG_COMP:     comp_rounds_r <= pwdata[3:0];
        sipsc_pkg::REG_FIN:      fin_rounds_r  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      sipsc_pkg::REG_KEY_LOW:  prdata = key_low_r;
      sipsc_pkg::REG_KEY_HIGH: prdata = key_high_r;
      sipsc_pkg::REG_COMP:     prdata = {60'd0, comp_rounds_r};
      sipsc_pkg::REG_FIN:      prdata = {60'd0, fin_rounds_r};
      default:                 prdata = 64'd0;
    endcase
  end

  assign full   = cmd_full;
  assign accept = push && !cmd_full;
  assign empty  = !out_valid;

  sipsc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_message_bytes (in_message_bytes),
    .in_byte_count    (in_byte_count),
    .in_last_item     (in_last_item),
    .cmd_push         (cmd_push),
    .cmd              (cmd_in)
  );

  sipsc_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_out),
    .valid   (cmd_valid)
  );

  sipsc_back #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .key_low     (key_low_r),
    .key_high    (key_high_r),
    .comp_rounds (comp_rounds_r),
    .fin_rounds  (fin_rounds_r),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd_out),
    .cmd_pop     (cmd_pop),
    .busy        (back_busy),
    .out_valid   (out_valid),
    .out_digest  (out_digest),
    .out_pop     (pop)
  );

  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty queue");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !back_busy)
    else $error("command taken while the round engine is busy");

  a_digest_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> $past(back_busy))
    else $error("digest appeared without a finalisation pass");

endmodule

// ===== tb/tb_siphash_streaming_cd_core.sv =====
// Self-checking testbench for siphash_streaming_cd_core: random bursts of message
// beats against a built-in SipHash-c-d predictor, with register changes between phases.
// Depends on rtl/sipsc_pkg.sv and rtl/siphash_streaming_cd_core.sv.
`timescale 1ns / 1ps

module tb_siphash_streaming_cd_core;

  localparam int RND_CAP      = 15;
  localparam int DRAIN_CYCLES = 150;
  localparam int STALL_LIMIT  = 4000;
  localparam int TARGET_BEATS = 450;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] in_message_bytes = '0;
  logic [3:0]  in_byte_count = '0;
  logic        in_last_item = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] out_digest;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  beat_t       beat_q[$];
  logic [63:0] digest_q[$];

  logic [63:0] key_lo, key_hi;
  logic [3:0]  comp_rounds, fin_rounds;
  logic [63:0] lanes[4];
  logic [63:0] tail_bytes = '0;
  int          tail_cnt = 0;
  logic [7:0]  msg_len = '0;
  bit          in_msg = 1'b0;

  int n_queued, n_beats, n_digests, n_mismatch, n_writes, n_holds;
  int burst_left, gap_left;
  int hold_token, hold_seen, hold_left;
  int rx_cycle, idle_cycles;

  siphash_streaming_cd_core u_top (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_message_bytes(in_message_bytes), .in_byte_count(in_byte_count),
    .in_last_item(in_last_item),
    .empty(empty), .pop(pop), .out_digest(out_digest),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int s);
    return (x << s) | (x >> (64 - s));
  endfunction

  function automatic void sip_rounds(input logic [3:0] count);
    logic [63:0] a, b, c, d;
    int n, i;
    n = (count > RND_CAP) ? RND_CAP : count;
    a = lanes[0]; b = lanes[1]; c = lanes[2]; d = lanes[3];
    for (i = 0; i < n; i++) begin
      a = a + b; c = c + d;
      b = rotl64(b, 13); d = rotl64(d, 16);
      b ^= a; d ^= c;
      a = rotl64(a, 32);
      c = c + b; a = a + d;
      b = rotl64(b, 17); d = rotl64(d, 21);
      b ^= c; d ^= a;
      c = rotl64(c, 32);
    end
    lanes[0] = a; lanes[1] = b; lanes[2] = c; lanes[3] = d;
  endfunction

  function automatic void compress_block(input logic [63:0] m);
    lanes[3] ^= m;
    sip_rounds(comp_rounds);
    lanes[0] ^= m;
  endfunction

  function automatic void sip_predict_beat(input beat_t b);
    logic [63:0]  kept, mask, fin_block;
    logic [127:0] joined;
    int n;
    if (!in_msg) begin
      lanes[0] = key_lo ^ sipsc_pkg::INIT0;
      lanes[1] = key_hi ^ sipsc_pkg::INIT1;
      lanes[2] = key_lo ^ sipsc_pkg::INIT2;
      lanes[3] = key_hi ^ sipsc_pkg::INIT3;
      tail_bytes = '0;
      tail_cnt = 0;
      msg_len = '0;
      in_msg = 1'b1;
    end
    n = (b.count > 8) ? 8 : int'(b.count);
    mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    kept = b.data & mask;
    msg_len = msg_len + 8'(n);
    joined = {64'd0, tail_bytes} | ({64'd0, kept} << (8 * tail_cnt));
    if (tail_cnt + n >= 8) begin
      compress_block(joined[63:0]);
      tail_bytes = joined[127:64];
      tail_cnt = tail_cnt + n - 8;
    end else begin
      tail_bytes = joined[63:0];
      tail_cnt = tail_cnt + n;
    end
    if (b.last) begin
      fin_block = tail_bytes | {msg_len, 56'd0};
      compress_block(fin_block);
      lanes[2] ^= {56'd0, sipsc_pkg::FINAL_MARK};
      sip_rounds(fin_rounds);
      digest_q.push_back(lanes[0] ^ lanes[1] ^ lanes[2] ^ lanes[3]);
      tail_bytes = '0;
      tail_cnt = 0;
      msg_len = '0;
      in_msg = 1'b0;
    end
  endfunction

  // Sender: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      burst_left <= 4;
      gap_left <= 0;
    end else if (!(push && full)) begin
      if (push) begin
        sip_predict_beat('{in_message_bytes, in_byte_count, in_last_item});
        n_beats++;
      end
      if (gap_left > 0) begin
        push <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (beat_q.size() != 0) begin
        beat_t b;
        b = beat_q.pop_front();
        in_message_bytes <= b.data;
        in_byte_count <= b.count;
        in_last_item <= b.last;
        push <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          case ($urandom_range(0, 2))
            0: gap_left <= 0;
            1: gap_left <= $urandom_range(1, 4);
            default: gap_left <= $urandom_range(5, 20);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern chosen by rx_cycle[7:6], plus requested long holds.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      rx_cycle <= 0;
      hold_seen <= 0;
      hold_left <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (pop && !empty) begin
        if (digest_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected digest %h with nothing outstanding", out_digest);
        end else begin
          logic [63:0] want;
          want = digest_q.pop_front();
          if (want !== out_digest) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("digest %0d: expected %h, got %h", n_digests, want, out_digest);
          end
        end
        n_digests++;
      end
      if (hold_seen != hold_token) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_CYCLES;
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        case (rx_cycle[7:6])
          2'd0: pop <= 1'b1;
          2'd1: pop <= 1'($urandom_range(0, 1));
          2'd2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= rx_cycle[2];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles, %0d digests outstanding",
               idle_cycles, digest_q.size());
      $display("siphash_streaming_cd_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_beat(input logic [63:0] data, input logic [3:0] count,
                            input logic last);
    beat_q.push_back('{data, count, last});
    n_queued++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_message(input int nbytes);
    int remaining, eff;
    logic [3:0] code;
    bit closed;
    remaining = nbytes;
    closed = 0;
    while (remaining > 0) begin
      eff = $urandom_range(0, 8);
      if (eff > remaining) eff = remaining;
      code = 4'(eff);
      if (eff == 8 && $urandom_range(0, 3) == 0) code = 4'($urandom_range(9, 15));
      remaining -= eff;
      closed = (remaining == 0) && ($urandom_range(0, 2) != 0);
      queue_beat(rand64(), code, closed);
    end
    if (!closed) queue_beat(rand64(), 4'd0, 1'b1);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (beat_q.size() != 0 || push || digest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sipsc_pkg::REG_KEY_LOW:  key_lo = value;
      sipsc_pkg::REG_KEY_HIGH: key_hi = value;
      sipsc_pkg::REG_COMP:     comp_rounds = value[3:0];
      default:                 fin_rounds = value[3:0];
    endcase
    n_writes++;
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] pick_rounds();
    logic [3:0] r;
    case ($urandom_range(0, 6))
      0: r = 4'd0;
      1: r = 4'd1;
      2: r = 4'd2;
      3: r = 4'd4;
      4: r = 4'd15;
      default: r = 4'($urandom_range(0, 15));
    endcase
    return {60'(rand64() >> 4), r};
  endfunction

  function automatic int pick_length();
    case ($urandom_range(0, 19))
      0: return $urandom_range(250, 300);
      1, 2, 3, 4: return $urandom_range(25, 80);
      default: return $urandom_range(0, 24);
    endcase
  endfunction

  initial begin
    int phase;
    key_lo = '0;
    key_hi = '0;
    comp_rounds = sipsc_pkg::COMP_ROUNDS_RST;
    fin_rounds = sipsc_pkg::FIN_ROUNDS_RST;
    hold_token = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty message with stray bits, full block, oversized count,
    // then a message whose bytes straddle block boundaries.
    queue_beat('1, 4'd0, 1'b1);
    queue_beat('1, 4'd8, 1'b1);
    queue_beat(rand64(), 4'd15, 1'b1);
    queue_beat(rand64(), 4'd0, 1'b0);
    queue_beat(rand64(), 4'd3, 1'b0);
    queue_beat(rand64(), 4'd7, 1'b0);
    queue_beat('0, 4'd8, 1'b0);
    queue_beat(rand64(), 4'd1, 1'b1);
    wait_idle();

    cfg_write(sipsc_pkg::REG_KEY_LOW, 64'h0706050403020100);
    cfg_write(sipsc_pkg::REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
    queue_beat(64'h0706050403020100, 4'd8, 1'b0);
    queue_beat(64'hff0e0d0c0b0a0908, 4'd7, 1'b1);
    wait_idle();

    cfg_write(sipsc_pkg::REG_COMP, {60'hfffffffffffffff, 4'd0});
    cfg_write(sipsc_pkg::REG_FIN, {60'(rand64() >> 4), 4'd15});
    queue_beat(rand64(), 4'd5, 1'b0);
    queue_beat(rand64(), 4'd6, 1'b1);
    wait_idle();

    cfg_write(sipsc_pkg::REG_COMP, 64'd15);
    cfg_write(sipsc_pkg::REG_FIN, 64'd0);
    queue_beat(rand64(), 4'd4, 1'b0);
    queue_beat(rand64(), 4'd8, 1'b1);
    wait_idle();

    // A key written mid-message only applies from the following message.
    cfg_write(sipsc_pkg::REG_COMP, 64'd2);
    cfg_write(sipsc_pkg::REG_FIN, 64'd4);
    queue_beat(rand64(), 4'd8, 1'b0);
    queue_beat(rand64(), 4'd2, 1'b0);
    wait_idle();
    cfg_write(sipsc_pkg::REG_KEY_LOW, '1);
    cfg_write(sipsc_pkg::REG_KEY_HIGH, '1);
    queue_beat(rand64(), 4'd8, 1'b1);
    queue_beat(rand64(), 4'd3, 1'b1);

    // Round counts written mid-message apply to the next block at once.
    queue_beat(rand64(), 4'd6, 1'b0);
    wait_idle();
    cfg_write(sipsc_pkg::REG_COMP, 64'd1);
    cfg_write(sipsc_pkg::REG_FIN, 64'd1);
    queue_beat(rand64(), 4'd8, 1'b0);
    queue_beat(rand64(), 4'd0, 1'b1);
    wait_idle();
    cfg_write(sipsc_pkg::REG_COMP, 64'd2);
    cfg_write(sipsc_pkg::REG_FIN, 64'd4);

    phase = 0;
    while (n_queued < TARGET_BEATS) begin
      wait_idle();
      if ($urandom_range(0, 1)) cfg_write(sipsc_pkg::REG_KEY_LOW, pick_key());
      if ($urandom_range(0, 1)) cfg_write(sipsc_pkg::REG_KEY_HIGH, pick_key());
      if ($urandom_range(0, 2) == 0) cfg_write(sipsc_pkg::REG_COMP, pick_rounds());
      if ($urandom_range(0, 2) == 0) cfg_write(sipsc_pkg::REG_FIN, pick_rounds());
      if (phase % 9 == 1) begin
        hold_token++;
        n_holds++;
        repeat (10) queue_message($urandom_range(0, 16));
      end else begin
        repeat ($urandom_range(2, 8)) queue_message(pick_length());
      end
      phase++;
    end

    wait_idle();
    $display("%0d beats in %0d phases gave %0d digests; %0d register writes, %0d long holds",
             n_beats, phase, n_digests, n_writes, n_holds);
    $display("%0d mismatches, %0d digests never delivered", n_mismatch, digest_q.size());
    if (n_mismatch == 0 && digest_q.size() == 0) begin
      $display("siphash_streaming_cd_core regression: pass");
    end else begin
      $display("siphash_streaming_cd_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sipsc_pkg.sv
rtl/sipsc_front.sv
rtl/sipsc_cmd_fifo.sv
rtl/sipsc_back.sv
rtl/siphash_streaming_cd_core.sv
tb/tb_siphash_streaming_cd_core.sv
